[hw/rtl/seqc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence cone scorer package
// Shared constants, register indexes and the cone configuration struct.
// ----------------------------------------------------------------------------
package seqc_pkg;

    // Fixed field widths
    localparam int VEL_W      = 4;
    localparam int WIN_W      = 5;
    localparam int DBS_W      = 17;
    localparam int SCORE_W    = 16;
    localparam int FRAC_BITS  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Request kinds
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_SCORE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VEL = 3'd0,
        CFG_MAX_VEL = 3'd1,
        CFG_WINDOW  = 3'd2,
        CFG_DB_SIZE = 3'd3,
        CFG_BIDIR   = 3'd4
    } cfg_reg_t;

    // Register reset values
    localparam logic [VEL_W-1:0] MIN_VEL_RST = 4'd0;
    localparam logic [VEL_W-1:0] MAX_VEL_RST = 4'd2;
    localparam logic [WIN_W-1:0] WINDOW_RST  = 5'd10;
    localparam logic [DBS_W-1:0] DB_SIZE_RST = 17'h10000;

    // Cone settings broadcast along the cell chain
    typedef struct packed {
        logic [VEL_W-1:0] vel_min;
        logic [VEL_W-1:0] vel_max;
        logic             bidir;
        logic [DBS_W-1:0] last_idx;
    } cone_cfg_t;

endpackage

[hw/rtl/seqc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Push and score transactions into the scorer.
// ----------------------------------------------------------------------------
interface seqc_req_if #(
    parameter int IDX_W = 16
) ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] match_first;
    logic [IDX_W-1:0] match_second;
    logic [IDX_W-1:0] db_index;

    modport source (
        output valid, req_type, match_first, match_second, db_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, match_first, match_second, db_index,
        output ready
    );
endinterface

[hw/rtl/seqc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Score results out of the scorer.
// ----------------------------------------------------------------------------
interface seqc_rsp_if #(
    parameter int CNT_W = 6,
    parameter int LEN_W = 5
) ();
    logic             valid;
    logic             ready;
    logic [15:0]      score;
    logic [CNT_W-1:0] match_count;
    logic [LEN_W-1:0] window_length;

    modport source (
        output valid, score, match_count, window_length,
        input  ready
    );
    modport sink (
        input  valid, score, match_count, window_length,
        output ready
    );
endinterface

[hw/rtl/seqc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface seqc_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [16:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[hw/rtl/seqc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone cell
// Holds one query's two matches; tests them against the probe passing through
// and hands the probe, with bounds stepped by one query, to the next cell.
// ----------------------------------------------------------------------------
module seqc_cell
    import seqc_pkg::*;
#(
    parameter int IDX_W  = 16,
    parameter int CORD_W = 20,
    parameter int CNT_W  = 6,
    parameter int LEN_W  = 5,
    parameter bit FIRST  = 1'b0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cone_cfg_t                cone_cfg,
    // match history shift
    input  logic                     shift_en,
    input  logic [IDX_W-1:0]         m_first_in,
    input  logic [IDX_W-1:0]         m_second_in,
    output logic [IDX_W-1:0]         m_first_out,
    output logic [IDX_W-1:0]         m_second_out,
    // probe in
    input  logic                     probe_valid_in,
    input  logic [IDX_W-1:0]         probe_j_in,
    input  logic signed [CORD_W-1:0] probe_lo_in,
    input  logic signed [CORD_W-1:0] probe_hi_in,
    input  logic [CNT_W-1:0]         probe_cnt_in,
    input  logic [LEN_W-1:0]         probe_rem_in,
    // probe out
    output logic                     probe_valid_out,
    output logic [IDX_W-1:0]         probe_j_out,
    output logic signed [CORD_W-1:0] probe_lo_out,
    output logic signed [CORD_W-1:0] probe_hi_out,
    output logic [CNT_W-1:0]         probe_cnt_out,
    output logic [LEN_W-1:0]         probe_rem_out
);

    logic [IDX_W-1:0]         m_first_reg;
    logic [IDX_W-1:0]         m_second_reg;
    logic                     valid_reg;
    logic [IDX_W-1:0]         j_reg;
    logic signed [CORD_W-1:0] lo_reg;
    logic signed [CORD_W-1:0] hi_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [LEN_W-1:0]         rem_reg;

    logic signed [CORD_W-1:0] lo_next;
    logic signed [CORD_W-1:0] hi_next;
    logic [CNT_W-1:0]         cnt_next;
    logic [LEN_W-1:0]         rem_next;

    logic signed [CORD_W-1:0] last_s;
    logic signed [CORD_W-1:0] two_j;
    logic signed [CORD_W-1:0] lo_c;
    logic signed [CORD_W-1:0] hi_c;
    logic signed [CORD_W-1:0] mir_lo_raw;
    logic signed [CORD_W-1:0] mir_hi_raw;
    logic signed [CORD_W-1:0] mir_lo;
    logic signed [CORD_W-1:0] mir_hi;
    logic                     hit_first;
    logic                     hit_second;
    logic [CNT_W-1:0]         hit_cnt;

    // Match inside the cone, or inside its mirror when enabled
    function automatic logic cone_hit(
        input logic [IDX_W-1:0]         m,
        input logic signed [CORD_W-1:0] lo,
        input logic signed [CORD_W-1:0] hi,
        input logic signed [CORD_W-1:0] mlo,
        input logic signed [CORD_W-1:0] mhi,
        input logic                     bidir
    );
        logic signed [CORD_W-1:0] ms;
        ms = signed'(CORD_W'(m));
        return (ms >= lo && ms <= hi) || (bidir && ms >= mlo && ms <= mhi);
    endfunction

    // Cone bounds for this cell
    always_comb
    begin
        last_s     = signed'(CORD_W'(cone_cfg.last_idx));
        two_j      = signed'(CORD_W'(probe_j_in)) <<< 1;
        lo_c       = probe_lo_in[CORD_W-1] ? '0 : probe_lo_in;
        hi_c       = (FIRST && probe_hi_in > last_s) ? last_s : probe_hi_in;
        mir_lo_raw = two_j - hi_c;
        mir_hi_raw = two_j - lo_c;
        mir_lo     = (mir_lo_raw < last_s) ? mir_lo_raw : last_s;
        mir_hi     = (mir_hi_raw < last_s) ? mir_hi_raw : last_s;
        hit_first  = cone_hit(m_first_reg, lo_c, hi_c, mir_lo, mir_hi, cone_cfg.bidir);
        hit_second = cone_hit(m_second_reg, lo_c, hi_c, mir_lo, mir_hi, cone_cfg.bidir);
        hit_cnt    = CNT_W'(hit_first) + CNT_W'(hit_second);
    end

    // Probe update: count only while window entries remain
    always_comb
    begin
        lo_next  = probe_lo_in - signed'(CORD_W'(cone_cfg.vel_max));
        hi_next  = probe_hi_in - signed'(CORD_W'(cone_cfg.vel_min));
        cnt_next = (probe_rem_in != '0) ? probe_cnt_in + hit_cnt : probe_cnt_in;
        rem_next = (probe_rem_in != '0) ? probe_rem_in - LEN_W'(1) : probe_rem_in;
    end

    // Probe valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= probe_valid_in;
        end
    end

    // Probe payload and match history
    always_ff @(posedge clk)
    begin
        j_reg   <= probe_j_in;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        if (shift_en)
        begin
            m_first_reg  <= m_first_in;
            m_second_reg <= m_second_in;
        end
    end

    assign m_first_out     = m_first_reg;
    assign m_second_out    = m_second_reg;
    assign probe_valid_out = valid_reg;
    assign probe_j_out     = j_reg;
    assign probe_lo_out    = lo_reg;
    assign probe_hi_out    = hi_reg;
    assign probe_cnt_out   = cnt_reg;
    assign probe_rem_out   = rem_reg;

endmodule

[hw/rtl/seqc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle from start to done.
// ----------------------------------------------------------------------------
module seqc_div
    import seqc_pkg::*;
#(
    parameter int DIV_W = 20,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [DVS_W:0]    trial;
    logic              take;
    logic [DVS_W:0]    diff;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        take  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/sequence_cone_match_scorer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence cone match scorer
// Window of recent query matches held in a chain of cells; scores a database
// index by counting matches inside a velocity cone.
// ----------------------------------------------------------------------------
// Usage:
//   req : push transactions (req_type 0) shift match_first/match_second into
//         the history; score transactions (req_type 1) ask for db_index.
//   rsp : one transaction per score request: score (14 fraction bits),
//         match_count and window_length. Pushes give no response.
//   cfg : register writes, index 0..4 (min/max velocity, window size,
//         database size, bidirectional). Always ready; write only when idle.
// Throughput:
//   Pushes may follow back to back.
//   A score walks a probe down the cell chain, then runs the bit-serial
//   divider unless the window length is zero, and then hands the result to
//   the output register. Requests are taken one at a time; req.ready is low
//   while a score is in flight.
// Reset: history empties, registers take their defaults, no response pending.
// Stall: a finished result waits in the output register; a new request is
//   taken meanwhile, and the next result waits until rsp.ready frees it.
// ----------------------------------------------------------------------------
module sequence_cone_match_scorer
    import seqc_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int INDEX_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    seqc_req_if.sink   req,
    seqc_rsp_if.source rsp,
    seqc_cfg_if.sink   cfg
);

    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W  = $clog2(2 * WINDOW_DEPTH + 1);
    localparam int DIV_W  = CNT_W + FRAC_BITS;
    localparam int CORD_W = ((INDEX_BITS > DBS_W) ? INDEX_BITS : DBS_W) + 3;
    localparam int CMP_W  = (LEN_W > WIN_W) ? LEN_W : WIN_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [VEL_W-1:0]  vel_min_reg;
    logic [VEL_W-1:0]  vel_max_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [DBS_W-1:0]  db_size_reg;
    logic              bidir_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              inj_valid_reg;
    logic [INDEX_BITS-1:0] inj_j_reg;
    logic [SCORE_W-1:0] res_score_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic              out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [LEN_W-1:0]  out_len_reg;

    cone_cfg_t         cone_cfg;
    logic              req_acc;
    logic              push_acc;
    logic              score_acc;
    logic [CMP_W-1:0]  win_eff;
    logic [CMP_W-1:0]  fill_ext;
    logic [LEN_W-1:0]  len_calc;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_done;
    logic [DIV_W-1:0]  div_quotient;
    logic              out_free;

    // Chain taps: index 0 feeds the first cell, index WINDOW_DEPTH leaves the last
    logic [INDEX_BITS-1:0]    chain_m1    [WINDOW_DEPTH+1];
    logic [INDEX_BITS-1:0]    chain_m2    [WINDOW_DEPTH+1];
    logic                     probe_valid [WINDOW_DEPTH+1];
    logic [INDEX_BITS-1:0]    probe_j     [WINDOW_DEPTH+1];
    logic signed [CORD_W-1:0] probe_lo    [WINDOW_DEPTH+1];
    logic signed [CORD_W-1:0] probe_hi    [WINDOW_DEPTH+1];
    logic [CNT_W-1:0]         probe_cnt   [WINDOW_DEPTH+1];
    logic [LEN_W-1:0]         probe_rem   [WINDOW_DEPTH+1];

    // Handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_acc   = req.valid && req.ready;
    assign push_acc  = req_acc && (req.req_type == REQ_PUSH);
    assign score_acc = req_acc && (req.req_type == REQ_SCORE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Cone settings for the cells
    always_comb
    begin
        cone_cfg.vel_min  = vel_min_reg;
        cone_cfg.vel_max  = vel_max_reg;
        cone_cfg.bidir    = bidir_reg;
        cone_cfg.last_idx = (db_size_reg == '0) ? '0 : db_size_reg - DBS_W'(1);
    end

    // Window length for a new score
    always_comb
    begin
        win_eff = CMP_W'(window_reg);
        if (win_eff == '0)
        begin
            win_eff = CMP_W'(1);
        end
        else if (win_eff > CMP_W'(WINDOW_DEPTH))
        begin
            win_eff = CMP_W'(WINDOW_DEPTH);
        end
        fill_ext = CMP_W'(fill_reg);
        len_calc = (fill_ext < win_eff) ? fill_reg : LEN_W'(win_eff);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_min_reg <= MIN_VEL_RST;
            vel_max_reg <= MAX_VEL_RST;
            window_reg  <= WINDOW_RST;
            db_size_reg <= DB_SIZE_RST;
            bidir_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_MIN_VEL: vel_min_reg <= cfg.data[VEL_W-1:0];
                CFG_MAX_VEL: vel_max_reg <= cfg.data[VEL_W-1:0];
                CFG_WINDOW:  window_reg  <= cfg.data[WIN_W-1:0];
                CFG_DB_SIZE: db_size_reg <= cfg.data[DBS_W-1:0];
                CFG_BIDIR:   bidir_reg   <= cfg.data[0];
                default:     ;
            endcase
        end
    end

    // Cell chain inputs
    assign chain_m1[0]    = req.match_first;
    assign chain_m2[0]    = req.match_second;
    assign probe_valid[0] = inj_valid_reg;
    assign probe_j[0]     = inj_j_reg;
    assign probe_lo[0]    = signed'(CORD_W'(inj_j_reg));
    assign probe_hi[0]    = signed'(CORD_W'(inj_j_reg));
    assign probe_cnt[0]   = '0;
    assign probe_rem[0]   = len_reg;

    // Cell k holds the query k steps older than the newest
    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        seqc_cell #(
            .IDX_W  (INDEX_BITS),
            .CORD_W (CORD_W),
            .CNT_W  (CNT_W),
            .LEN_W  (LEN_W),
            .FIRST  (k == 0)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .cone_cfg        (cone_cfg),
            .shift_en        (push_acc),
            .m_first_in      (chain_m1[k]),
            .m_second_in     (chain_m2[k]),
            .m_first_out     (chain_m1[k+1]),
            .m_second_out    (chain_m2[k+1]),
            .probe_valid_in  (probe_valid[k]),
            .probe_j_in      (probe_j[k]),
            .probe_lo_in     (probe_lo[k]),
            .probe_hi_in     (probe_hi[k]),
            .probe_cnt_in    (probe_cnt[k]),
            .probe_rem_in    (probe_rem[k]),
            .probe_valid_out (probe_valid[k+1]),
            .probe_j_out     (probe_j[k+1]),
            .probe_lo_out    (probe_lo[k+1]),
            .probe_hi_out    (probe_hi[k+1]),
            .probe_cnt_out   (probe_cnt[k+1]),
            .probe_rem_out   (probe_rem[k+1])
        );
    end

    // Divider: (count * 2^14 + len / 2) / len
    assign div_start    = (state_reg == ST_WALK) && probe_valid[WINDOW_DEPTH]
                          && (len_reg != '0);
    assign div_dividend = {probe_cnt[WINDOW_DEPTH], {FRAC_BITS{1'b0}}}
                          + DIV_W'(len_reg >> 1);

    seqc_div #(
        .DIV_W (DIV_W),
        .DVS_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (score_acc) state_next = ST_WALK;
            ST_WALK:
            begin
                if (probe_valid[WINDOW_DEPTH])
                begin
                    state_next = (len_reg == '0) ? ST_HOLD : ST_DIVIDE;
                end
            end
            ST_DIVIDE: if (div_done) state_next = ST_HOLD;
            ST_HOLD:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            inj_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_valid_reg <= score_acc;
            if (push_acc && fill_reg != LEN_W'(WINDOW_DEPTH))
            begin
                fill_reg <= fill_reg + LEN_W'(1);
            end
            if (state_reg == ST_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, results and output register
    always_ff @(posedge clk)
    begin
        if (score_acc)
        begin
            inj_j_reg <= req.db_index;
            len_reg   <= len_calc;
        end
        if (state_reg == ST_WALK && probe_valid[WINDOW_DEPTH])
        begin
            res_score_reg <= '0;
            res_cnt_reg   <= probe_cnt[WINDOW_DEPTH];
        end
        if (state_reg == ST_DIVIDE && div_done)
        begin
            res_score_reg <= div_quotient[SCORE_W-1:0];
        end
        if (state_reg == ST_HOLD && out_free)
        begin
            out_score_reg <= res_score_reg;
            out_cnt_reg   <= res_cnt_reg;
            out_len_reg   <= len_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.score         = out_score_reg;
    assign rsp.match_count   = out_cnt_reg;
    assign rsp.window_length = out_len_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_W'(WINDOW_DEPTH))
        else $error("history fill beyond window depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && probe_valid[WINDOW_DEPTH])
        |-> (CNT_W'(probe_cnt[WINDOW_DEPTH]) <= CNT_W'({len_reg, 1'b0})))
        else $error("cone count exceeds two per window entry");

    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("response raised outside result hand-off");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> $past(state_reg == ST_DIVIDE))
        else $error("divider finished while not dividing");

endmodule
